[sv/bda_pkg.sv]
// Package for the button duty adjuster: register indexes, reset values,
// and the per-button result type. No dependencies.
`default_nettype none

package bda_pkg;

    localparam int unsigned DutyW = 8;
    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_HOLD_DELAY     = 3'd0,
        REG_MAX_DUTY       = 3'd1,
        REG_MIN_DUTY       = 3'd2,
        REG_INITIAL_DUTY   = 3'd3,
        REG_INITIAL_ENABLE = 3'd4
    } t_cfg_idx;

    localparam logic [DutyW-1:0] HOLD_DELAY_RST   = 8'd16;
    localparam logic [DutyW-1:0] MAX_DUTY_RST     = 8'd255;
    localparam logic [DutyW-1:0] MIN_DUTY_RST     = 8'd56;
    localparam logic [DutyW-1:0] INITIAL_DUTY_RST = 8'd127;
    localparam logic             INITIAL_EN_RST   = 1'b0;
    localparam logic [DutyW-1:0] LOCK_COUNT       = 8'hFF;

    typedef struct packed {
        logic [DutyW-1:0] count;
        logic             step;
    } t_btn_res;

endpackage

`default_nettype wire

[sv/bda_button.sv]
// Hold counter next-state and step decision for one button.
// Depends on bda_pkg.
`default_nettype none

module bda_button
    import bda_pkg::*;
(
    input  wire logic             i_held,
    input  wire logic [DutyW-1:0] i_count,
    input  wire logic [DutyW-1:0] i_hold_delay,
    output t_btn_res              o_res
);

    logic [DutyW-1:0] dec;

    always_comb begin
        dec = i_count - 8'd1;
        o_res.step  = 1'b0;
        o_res.count = '0;
        if (i_held) begin
            if (i_count == '0) begin
                o_res.count = i_hold_delay;
            end else if (dec == '0) begin
                o_res.step  = 1'b1;
                o_res.count = 8'd1;
            end else begin
                o_res.count = dec;
            end
        end else begin
            o_res.step = (i_count > 8'd1) && (i_count < i_hold_delay);
        end
    end

endmodule

`default_nettype wire

[sv/bda_setpoint.sv]
// Duty saturation, dual-press enable toggle and counter lock for one tick.
// Depends on bda_pkg.
`default_nettype none

module bda_setpoint
    import bda_pkg::*;
(
    input  wire t_btn_res         i_up,
    input  wire t_btn_res         i_down,
    input  wire logic [DutyW-1:0] i_duty,
    input  wire logic             i_enable,
    input  wire logic [DutyW-1:0] i_hold_delay,
    input  wire logic [DutyW-1:0] i_max_duty,
    input  wire logic [DutyW-1:0] i_min_duty,
    output logic      [DutyW-1:0] o_up_count,
    output logic      [DutyW-1:0] o_down_count,
    output logic      [DutyW-1:0] o_duty,
    output logic                  o_enable,
    output logic                  o_save_enable,
    output logic                  o_save_duty
);

    logic [DutyW-1:0] duty_up;

    always_comb begin
        duty_up = i_duty;
        if (i_up.step && (i_duty < i_max_duty)) begin
            duty_up = i_duty + 8'd1;
        end
        o_duty = duty_up;
        if (i_down.step && (duty_up > i_min_duty)) begin
            o_duty = duty_up - 8'd1;
        end

        o_up_count    = i_up.count;
        o_down_count  = i_down.count;
        o_enable      = i_enable;
        o_save_enable = 1'b0;
        o_save_duty   = 1'b0;
        if ((i_up.count > 8'd1) && (i_down.count > 8'd1)) begin
            if (i_up.count <= i_hold_delay) begin
                o_enable      = ~i_enable;
                o_save_enable = 1'b1;
                o_save_duty   = i_enable;
            end
            o_up_count   = LOCK_COUNT;
            o_down_count = LOCK_COUNT;
        end
    end

endmodule

`default_nettype wire

[sv/button_duty_adjuster_top.sv]
// Button duty adjuster: up/down setpoint with auto-repeat and enable toggle.
// The result is registered from the accepted input transaction.
// Throughput: one transaction per cycle; input is taken while the output
// register is empty or being drained in the same cycle.
// Reset (synchronous, active low): config registers to defaults, counters to
// zero, setpoint 127, enable 0, output register empty.
`default_nettype none

module button_duty_adjuster_top
    import bda_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [DutyW-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_up_pressed,
    input  wire logic               i_down_pressed,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [DutyW-1:0]   o_drive_duty,
    output logic      [DutyW-1:0]   o_duty_setpoint,
    output logic                    o_enabled,
    output logic                    o_save_enable,
    output logic                    o_save_duty
);

    logic [DutyW-1:0] r_hold_delay, r_max_duty, r_min_duty;
    logic [DutyW-1:0] r_up_count, r_down_count, r_duty;
    logic             r_enable;
    logic             r_out_valid;
    logic [DutyW-1:0] r_drive_duty, r_duty_setpoint;
    logic             r_enabled, r_save_enable, r_save_duty;

    t_btn_res         up_res, down_res;
    logic [DutyW-1:0] n_up_count, n_down_count, n_duty;
    logic             n_enable, n_save_enable, n_save_duty;
    logic             accept;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign accept     = i_in_valid & o_in_ready;

    bda_button u_up (
        .i_held       (i_up_pressed),
        .i_count      (r_up_count),
        .i_hold_delay (r_hold_delay),
        .o_res        (up_res)
    );

    bda_button u_down (
        .i_held       (i_down_pressed),
        .i_count      (r_down_count),
        .i_hold_delay (r_hold_delay),
        .o_res        (down_res)
    );

    bda_setpoint u_setpoint (
        .i_up          (up_res),
        .i_down        (down_res),
        .i_duty        (r_duty),
        .i_enable      (r_enable),
        .i_hold_delay  (r_hold_delay),
        .i_max_duty    (r_max_duty),
        .i_min_duty    (r_min_duty),
        .o_up_count    (n_up_count),
        .o_down_count  (n_down_count),
        .o_duty        (n_duty),
        .o_enable      (n_enable),
        .o_save_enable (n_save_enable),
        .o_save_duty   (n_save_duty)
    );

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_delay <= HOLD_DELAY_RST;
            r_max_duty   <= MAX_DUTY_RST;
            r_min_duty   <= MIN_DUTY_RST;
            r_up_count   <= '0;
            r_down_count <= '0;
            r_duty       <= INITIAL_DUTY_RST;
            r_enable     <= INITIAL_EN_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_up_count   <= n_up_count;
                r_down_count <= n_down_count;
                r_duty       <= n_duty;
                r_enable     <= n_enable;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_idx))
                    REG_HOLD_DELAY:     r_hold_delay <= i_cfg_data;
                    REG_MAX_DUTY:       r_max_duty   <= i_cfg_data;
                    REG_MIN_DUTY:       r_min_duty   <= i_cfg_data;
                    REG_INITIAL_DUTY:   r_duty       <= i_cfg_data;
                    REG_INITIAL_ENABLE: r_enable     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive_duty    <= n_enable ? n_duty : '0;
            r_duty_setpoint <= n_duty;
            r_enabled       <= n_enable;
            r_save_enable   <= n_save_enable;
            r_save_duty     <= n_save_duty;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_duty    = r_drive_duty;
    assign o_duty_setpoint = r_duty_setpoint;
    assign o_enabled       = r_enabled;
    assign o_save_enable   = r_save_enable;
    assign o_save_duty     = r_save_duty;

endmodule

`default_nettype wire
